FILE: hdl/arfmt_pkg.sv
package arfmt_pkg;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } eng_state_t;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_DATA      = 2'd0;
  localparam status_t STATUS_PREBUF    = 2'd1;
  localparam status_t STATUS_UNDERFLOW = 2'd2;

  localparam logic MODE_16 = 1'b0;
  localparam logic MODE_32 = 1'b1;

  localparam logic [3:0] BYTES_16 = 4'd4;
  localparam logic [3:0] BYTES_32 = 4'd8;

endpackage

FILE: hdl/arfmt_cmd_queue.sv
module arfmt_cmd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [7:0]       in_data_byte,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output arfmt_pkg::cmd_t  cmd
);

  arfmt_pkg::cmd_t q_r [2];
  logic            head_r, head_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            tail;
  logic            push;
  logic            pop;
  arfmt_pkg::cmd_t new_cmd;

  assign in_ready  = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[head_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign tail      = head_r ^ (count_r == 2'd1);

  always_comb begin
    new_cmd.kind      = in_action ? arfmt_pkg::CMD_FETCH : arfmt_pkg::CMD_PUSH;
    new_cmd.data_byte = in_data_byte;
  end

  always_comb begin
    head_nxt  = pop ? ~head_r : head_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail] <= new_cmd;
    end
  end

endmodule

FILE: hdl/arfmt_engine.sv
module arfmt_engine #(
  parameter int RING_SIZE        = 1024,
  parameter int FRAMES_PER_BLOCK = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sample_mode,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  arfmt_pkg::cmd_t      cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_left_high,
  output logic [15:0]          out_left_low,
  output logic [15:0]          out_right_high,
  output logic [15:0]          out_right_low,
  output logic [1:0]           out_block_status,
  output logic                 out_last_frame,
  output logic [31:0]          out_underflow_total
);

  localparam int AW = $clog2(RING_SIZE);
  localparam int FW = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
  localparam logic [AW-1:0] LAST_IDX   = AW'(RING_SIZE - 1);
  localparam logic [AW:0]   RING_EXT   = (AW + 1)'(RING_SIZE);
  localparam logic [31:0]   HALF_FILL  = 32'(RING_SIZE / 2);
  localparam logic [31:0]   FULL_FILL  = 32'(RING_SIZE - 1);
  localparam logic [31:0]   NEED_16    = 32'(FRAMES_PER_BLOCK * 4);
  localparam logic [31:0]   NEED_32    = 32'(FRAMES_PER_BLOCK * 8);
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES_PER_BLOCK - 1);

  logic [7:0] ring_mem [RING_SIZE];
  logic [7:0] rdata_r;

  arfmt_pkg::eng_state_t state_r, state_nxt;

  logic [AW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                playing_r, playing_nxt;
  logic [31:0]         uflow_r, uflow_nxt;
  arfmt_pkg::status_t  status_r, status_nxt;
  logic [FW-1:0]       frame_cnt_r, frame_cnt_nxt;
  logic [3:0]          byte_cnt_r, byte_cnt_nxt;
  logic                rvld_r, rvld_nxt;
  logic [63:0]         asm_r, asm_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         lh_r, lh_nxt, ll_r, ll_nxt, rh_r, rh_nxt, rl_r, rl_nxt;
  arfmt_pkg::status_t  ostat_r, ostat_nxt;
  logic                olast_r, olast_nxt;
  logic [31:0]         ouflow_r, ouflow_nxt;

  logic [AW:0]         fill;
  logic [31:0]         fill32;
  logic [31:0]         need32;
  logic [3:0]          nbytes;
  arfmt_pkg::status_t  fetch_status;
  logic                take_fetch;
  logic                take_push;
  logic                out_free;
  logic                emit_fire;
  logic                mem_we;
  logic                read_done;

  // fill level of the ring
  assign fill   = (wr_idx_r >= rd_idx_r) ? ({1'b0, wr_idx_r} - {1'b0, rd_idx_r})
                                         : ({1'b0, wr_idx_r} + RING_EXT - {1'b0, rd_idx_r});
  assign fill32 = 32'(fill);
  assign need32 = (sample_mode == arfmt_pkg::MODE_32) ? NEED_32 : NEED_16;
  assign nbytes = (sample_mode == arfmt_pkg::MODE_32) ? arfmt_pkg::BYTES_32
                                                      : arfmt_pkg::BYTES_16;

  always_comb begin
    if (!playing_r && (fill32 < HALF_FILL)) begin
      fetch_status = arfmt_pkg::STATUS_PREBUF;
    end else if (fill32 < need32) begin
      fetch_status = arfmt_pkg::STATUS_UNDERFLOW;
    end else begin
      fetch_status = arfmt_pkg::STATUS_DATA;
    end
  end

  assign take_fetch = (state_r == arfmt_pkg::ST_IDLE) && cmd_valid &&
                      (cmd.kind == arfmt_pkg::CMD_FETCH);
  assign take_push  = (state_r == arfmt_pkg::ST_IDLE) && cmd_valid &&
                      (cmd.kind == arfmt_pkg::CMD_PUSH);
  assign out_free   = !out_valid_r || out_ready;
  assign emit_fire  = (state_r == arfmt_pkg::ST_EMIT) && out_free;
  assign mem_we     = take_push && (fill32 < FULL_FILL);
  assign read_done  = (state_r == arfmt_pkg::ST_READ) && (byte_cnt_r == nbytes) && rvld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arfmt_pkg::ST_IDLE: begin
        if (take_fetch) begin
          state_nxt = (fetch_status == arfmt_pkg::STATUS_DATA) ? arfmt_pkg::ST_READ
                                                               : arfmt_pkg::ST_EMIT;
        end
      end
      arfmt_pkg::ST_READ: begin
        if (read_done) begin
          state_nxt = arfmt_pkg::ST_EMIT;
        end
      end
      arfmt_pkg::ST_EMIT: begin
        if (out_free) begin
          if (frame_cnt_r == LAST_FRAME) begin
            state_nxt = arfmt_pkg::ST_IDLE;
          end else if (status_r == arfmt_pkg::STATUS_DATA) begin
            state_nxt = arfmt_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = arfmt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_ready     = (state_r == arfmt_pkg::ST_IDLE);
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    playing_nxt   = playing_r;
    uflow_nxt     = uflow_r;
    status_nxt    = status_r;
    frame_cnt_nxt = frame_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    rvld_nxt      = 1'b0;
    asm_nxt       = asm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    lh_nxt        = lh_r;
    ll_nxt        = ll_r;
    rh_nxt        = rh_r;
    rl_nxt        = rl_r;
    ostat_nxt     = ostat_r;
    olast_nxt     = olast_r;
    ouflow_nxt    = ouflow_r;

    if (mem_we) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
    end

    if (take_fetch) begin
      if (!playing_r && (fill32 >= HALF_FILL)) begin
        playing_nxt = 1'b1;
      end
      if (fetch_status == arfmt_pkg::STATUS_UNDERFLOW) begin
        uflow_nxt = uflow_r + 32'd1;
      end
      status_nxt    = fetch_status;
      frame_cnt_nxt = '0;
      byte_cnt_nxt  = '0;
    end

    if (state_r == arfmt_pkg::ST_READ) begin
      // one ring byte per cycle, data lands in the cycle after its address
      if (byte_cnt_r != nbytes) begin
        rd_idx_nxt   = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
        byte_cnt_nxt = byte_cnt_r + 4'd1;
        rvld_nxt     = 1'b1;
      end
      if (rvld_r) begin
        asm_nxt = {rdata_r, asm_r[63:8]};
      end
    end

    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      ostat_nxt     = status_r;
      olast_nxt     = (frame_cnt_r == LAST_FRAME);
      ouflow_nxt    = uflow_r;
      if (status_r != arfmt_pkg::STATUS_DATA) begin
        lh_nxt = 16'h0000;
        ll_nxt = 16'h0000;
        rh_nxt = 16'h0000;
        rl_nxt = 16'h0000;
      end else if (sample_mode == arfmt_pkg::MODE_16) begin
        lh_nxt = asm_r[47:32];
        ll_nxt = 16'h0000;
        rh_nxt = asm_r[63:48];
        rl_nxt = 16'h0000;
      end else begin
        lh_nxt = asm_r[31:16];
        ll_nxt = asm_r[15:0];
        rh_nxt = asm_r[63:48];
        rl_nxt = asm_r[47:32];
      end
      frame_cnt_nxt = frame_cnt_r + 1'b1;
      byte_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arfmt_pkg::ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      playing_r   <= 1'b0;
      uflow_r     <= '0;
      status_r    <= arfmt_pkg::STATUS_DATA;
      frame_cnt_r <= '0;
      byte_cnt_r  <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      playing_r   <= playing_nxt;
      uflow_r     <= uflow_nxt;
      status_r    <= status_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r    <= asm_nxt;
    lh_r     <= lh_nxt;
    ll_r     <= ll_nxt;
    rh_r     <= rh_nxt;
    rl_r     <= rl_nxt;
    ostat_r  <= ostat_nxt;
    olast_r  <= olast_nxt;
    ouflow_r <= ouflow_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_idx_r] <= cmd.data_byte;
    end
    rdata_r <= ring_mem[rd_idx_r];
  end

  assign out_valid           = out_valid_r;
  assign out_left_high       = lh_r;
  assign out_left_low        = ll_r;
  assign out_right_high      = rh_r;
  assign out_right_low       = rl_r;
  assign out_block_status    = ostat_r;
  assign out_last_frame      = olast_r;
  assign out_underflow_total = ouflow_r;

  a_data_needs_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ostat_r == arfmt_pkg::STATUS_DATA)) |-> playing_r)
    else $error("data frame shown before prebuffering finished");

  a_silent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ostat_r != arfmt_pkg::STATUS_DATA)) |->
    (lh_r == 16'h0000 && ll_r == 16'h0000 && rh_r == 16'h0000 && rl_r == 16'h0000))
    else $error("silent frame carries nonzero sample");

  a_uflow_only_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (uflow_r != $past(uflow_r)) |-> $past(take_fetch))
    else $error("underflow counter moved outside a fetch decision");

  a_byte_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arfmt_pkg::ST_READ) |-> (byte_cnt_r <= nbytes))
    else $error("read overran the frame byte count");

  a_ring_idle_during_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != arfmt_pkg::ST_IDLE) |=> (wr_idx_r == $past(wr_idx_r)))
    else $error("ring written while a block is in progress");

endmodule

FILE: hdl/audio_ring_to_i2s_slot_formatter.sv
// Channel  Ports                                   Handshake
// in       in_action, in_data_byte                 in_valid / in_ready
// out      out_left_high .. out_underflow_total    out_valid / out_ready
// cfg      cfg_wdata (sample_mode)                 cfg_we, no wait
//
// A push is handled in the engine's idle state once it leaves the two-entry command queue.
// A fetch gives FRAMES_PER_BLOCK frames: a data frame takes 4 or 8 ring reads (one
// per cycle on the single ring read port) and then its emit; a silent frame is
// emitted without ring reads.
// Reset (synchronous, rst_n low) empties the ring, clears prebuffering and the
// underflow count, and sets sample_mode to 32-bit.
// A stalled output holds the engine; the queue keeps accepting up to two items.
module audio_ring_to_i2s_slot_formatter #(
  parameter int RING_SIZE        = 1024,
  parameter int FRAMES_PER_BLOCK = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_left_high,
  output logic [15:0] out_left_low,
  output logic [15:0] out_right_high,
  output logic [15:0] out_right_low,
  output logic [1:0]  out_block_status,
  output logic        out_last_frame,
  output logic [31:0] out_underflow_total
);

  logic            sample_mode_r, sample_mode_nxt;
  logic            cmd_valid;
  logic            cmd_ready;
  arfmt_pkg::cmd_t cmd;

  assign sample_mode_nxt = cfg_we ? cfg_wdata : sample_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_mode_r <= arfmt_pkg::MODE_32;
    end else begin
      sample_mode_r <= sample_mode_nxt;
    end
  end

  arfmt_cmd_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  arfmt_engine #(
    .RING_SIZE        (RING_SIZE),
    .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .sample_mode         (sample_mode_r),
    .cmd_valid           (cmd_valid),
    .cmd_ready           (cmd_ready),
    .cmd                 (cmd),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_left_high       (out_left_high),
    .out_left_low        (out_left_low),
    .out_right_high      (out_right_high),
    .out_right_low       (out_right_low),
    .out_block_status    (out_block_status),
    .out_last_frame      (out_last_frame),
    .out_underflow_total (out_underflow_total)
  );

endmodule
